// ===== design/dfm_pkg.sv =====
// Shared types and constants for the debounced fault monitor.
// Holds the stream payload layouts, command codes, register indexes and debounce counts.
// No dependencies.
`timescale 1ns / 1ps

package dfm_pkg;

    localparam int NUM_CH  = 11;
    localparam int NUM_MOD = 5;

    // Channel positions in the fault vectors
    localparam int CH_ACC     = 0;
    localparam int CH_RTC     = 1;
    localparam int CH_R3_HIGH = 2;
    localparam int CH_R3_LOW  = 3;
    localparam int CH_R5_HIGH = 4;
    localparam int CH_R5_LOW  = 5;
    localparam int CH_DC_HIGH = 6;
    localparam int CH_AUDIO   = 7;
    localparam int CH_TRACKS  = 8;
    localparam int CH_WIFI    = 9;
    localparam int CH_MEMORY  = 10;

    // Status flag bit positions
    localparam int FL_ACC_READY    = 0;
    localparam int FL_RTC_READABLE = 1;
    localparam int FL_POWER        = 2;
    localparam int FL_AUD_PRESENT  = 3;
    localparam int FL_AUD_FAULT    = 4;
    localparam int FL_AUD_READY    = 5;
    localparam int FL_AUD_RESP     = 6;
    localparam int FL_AUD_MODULE   = 7;
    localparam int FL_COUNT_VALID  = 8;
    localparam int FL_WIFI_PRESENT = 9;
    localparam int FL_WIFI_ERROR   = 10;
    localparam int FL_SUMMARY      = 11;
    localparam int FL_FLASH_READY  = 12;
    localparam int FL_MEM_READY    = 13;

    // Command codes carried in tuser
    localparam logic [2:0] CMD_SAMPLE    = 3'd0;
    localparam logic [2:0] CMD_SET_EXT   = 3'd1;
    localparam logic [2:0] CMD_CLEAR_EXT = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_CONSUME   = 3'd4;
    localparam logic [2:0] CMD_RESET_WIN = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_R3_HIGH  = 3'd0;
    localparam logic [2:0] REG_R3_LOW   = 3'd1;
    localparam logic [2:0] REG_R3_HYST  = 3'd2;
    localparam logic [2:0] REG_R5_HIGH  = 3'd3;
    localparam logic [2:0] REG_R5_LOW   = 3'd4;
    localparam logic [2:0] REG_DC_HIGH  = 3'd5;
    localparam logic [2:0] REG_R5_HYST  = 3'd6;
    localparam logic [2:0] REG_CLK_MIN  = 3'd7;

    // Register reset values
    localparam logic [11:0] RST_R3_HIGH = 12'd360;
    localparam logic [11:0] RST_R3_LOW  = 12'd300;
    localparam logic [7:0]  RST_R3_HYST = 8'd5;
    localparam logic [11:0] RST_R5_HIGH = 12'd550;
    localparam logic [11:0] RST_R5_LOW  = 12'd450;
    localparam logic [11:0] RST_DC_HIGH = 12'd800;
    localparam logic [7:0]  RST_R5_HYST = 8'd10;
    localparam logic [31:0] RST_CLK_MIN = 32'd41904000;

    localparam logic [15:0] MIN_TRACKS = 16'd1;

    // Debounce counts, channel 10 in the top slot down to channel 0
    localparam logic [NUM_CH-1:0][2:0] SET_COUNT =
        {3'd1, 3'd3, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1};
    localparam logic [NUM_CH-1:0][2:0] CLEAR_COUNT =
        {3'd3, 3'd5, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd1, 3'd3};

    // Channels held while power is absent
    localparam logic [NUM_CH-1:0] POWER_CH_MASK = 11'h07C;

    typedef struct packed {
        logic       active;
        logic [2:0] set_cnt;
        logic [2:0] clr_cnt;
    } deb_state_t;

    // Input payload, last field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic [NUM_CH-1:0] fault_mask;
        logic [31:0]       clock_seconds;
        logic [15:0]       track_count;
        logic [11:0]       supply_level;
        logic [11:0]       rail5_level;
        logic [11:0]       rail3_level;
        logic [13:0]       status_flags;
    } in_item_t;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [NUM_MOD-1:0] window_module_ok;
        logic [NUM_MOD-1:0] current_module_ok;
        logic [NUM_CH-1:0]  window_faults;
        logic [NUM_CH-1:0]  current_faults;
    } out_item_t;

endpackage

// ===== design/debounced_fault_monitor.sv =====
// Debounced fault monitor top level: eleven debounced fault channels, external
// faults and a sticky fault window. Depends on dfm_pkg.
`timescale 1ns / 1ps

// Usage
//   Requests arrive on the s_ stream: tuser carries the command (sample, set
//   external, clear external, read, consume window, reset window), tdata the
//   status flags, rail levels, track count, RTC seconds and fault mask. Every
//   request produces exactly one result on the m_ stream with the current and
//   window fault vectors and their per-module OK bits.
//   Thresholds and the clock validity limit are written through cfg_we /
//   cfg_addr / cfg_wdata while no request is in flight.
//   Timing: an accepted request is registered in the request register, then
//   evaluated and written to the result register, which drives m_tvalid.
//   Throughput: one request per cycle while the result register is free or
//   draining; all eleven channels update in parallel through one level of
//   compare and counter logic between the request and result registers.
//   Reset (aresetn low, synchronous) clears all debounce counters, fault
//   vectors and the window, and restores the register defaults.
//   When the receiver stalls, the result register holds its value and the
//   request register holds one more request; s_tready drops only when both
//   are full.

module debounced_fault_monitor (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    // Request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, low bit up: status_flags[13:0], rail3_level[25:14], rail5_level[37:26],
    // supply_level[49:38], track_count[65:50], clock_seconds[97:66],
    // fault_mask[108:98], zero pad[111:109]
    input  logic [111:0] s_tdata,
    // tuser: command[2:0]
    input  logic [2:0]   s_tuser,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, low bit up: current_faults[10:0], window_faults[21:11],
    // current_module_ok[26:22], window_module_ok[31:27]
    output logic [31:0]  m_tdata
);

    localparam int NCH = dfm_pkg::NUM_CH;

    // Configuration registers
    logic [11:0] r3_high_reg, r3_low_reg, r5_high_reg, r5_low_reg, dc_high_reg;
    logic [7:0]  r3_hyst_reg, r5_hyst_reg;
    logic [31:0] clk_min_reg;

    // Request register
    logic              in_valid_reg;
    dfm_pkg::in_item_t in_item_reg;
    logic [2:0]        in_cmd_reg;

    // Monitor state
    dfm_pkg::deb_state_t [NCH-1:0] deb_reg, deb_next;
    logic [NCH-1:0] auto_reg, auto_next;
    logic [NCH-1:0] ext_reg, ext_next;
    logic [NCH-1:0] win_reg, win_next;

    // Result register
    logic               m_tvalid_reg;
    dfm_pkg::out_item_t out_reg, out_next;

    logic out_free;
    logic proc;

    assign out_free = !m_tvalid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // One debounce step of a channel
    function automatic dfm_pkg::deb_state_t deb_step(input dfm_pkg::deb_state_t cur,
                                                     input logic fault,
                                                     input logic [2:0] nset,
                                                     input logic [2:0] nclr);
        dfm_pkg::deb_state_t nx;
        logic [2:0] cnt;
        nx = cur;
        if (cur.active) begin
            if (fault) begin
                nx.clr_cnt = 3'd0;
                nx.set_cnt = nset;
            end else begin
                nx.set_cnt = 3'd0;
                cnt = (cur.clr_cnt < nclr) ? cur.clr_cnt + 3'd1 : cur.clr_cnt;
                if (cnt >= nclr) begin
                    nx.active  = 1'b0;
                    nx.clr_cnt = 3'd0;
                end else begin
                    nx.clr_cnt = cnt;
                end
            end
        end else begin
            if (fault) begin
                nx.clr_cnt = 3'd0;
                cnt = (cur.set_cnt < nset) ? cur.set_cnt + 3'd1 : cur.set_cnt;
                if (cnt >= nset) begin
                    nx.active  = 1'b1;
                    nx.set_cnt = nset;
                end else begin
                    nx.set_cnt = cnt;
                end
            end else begin
                nx.set_cnt = 3'd0;
                nx.clr_cnt = nclr;
            end
        end
        return nx;
    endfunction

    // Overvoltage compare; the clear point is taken without wrap
    function automatic logic high_cmp(input logic active, input logic [11:0] lvl,
                                      input logic [11:0] set, input logic [7:0] hyst);
        logic [12:0] sum;
        sum = {1'b0, lvl} + {5'd0, hyst};
        return active ? (sum >= {1'b0, set}) : (lvl > set);
    endfunction

    // Undervoltage compare
    function automatic logic low_cmp(input logic active, input logic [11:0] lvl,
                                     input logic [11:0] set, input logic [7:0] hyst);
        logic [12:0] sum;
        sum = {1'b0, set} + {5'd0, hyst};
        return active ? ({1'b0, lvl} <= sum) : (lvl < set);
    endfunction

    function automatic logic [dfm_pkg::NUM_MOD-1:0] module_ok(input logic [NCH-1:0] f);
        return {~|f[10], ~|f[9], ~|f[8:7], ~|f[6:2], ~|f[1:0]};
    endfunction

    // Channel evaluation
    logic [13:0]    fl;
    logic [NCH-1:0] cond;
    logic           track_qual;
    logic [NCH-1:0] sample_faults;

    always_comb begin
        fl = in_item_reg.status_flags;
        track_qual = fl[dfm_pkg::FL_AUD_PRESENT] && fl[dfm_pkg::FL_AUD_READY]
                     && !fl[dfm_pkg::FL_AUD_FAULT] && fl[dfm_pkg::FL_AUD_MODULE]
                     && fl[dfm_pkg::FL_COUNT_VALID];

        cond[dfm_pkg::CH_ACC] = !fl[dfm_pkg::FL_ACC_READY];
        cond[dfm_pkg::CH_RTC] = !fl[dfm_pkg::FL_RTC_READABLE]
                                || (in_item_reg.clock_seconds < clk_min_reg);
        cond[dfm_pkg::CH_R3_HIGH] = high_cmp(deb_reg[dfm_pkg::CH_R3_HIGH].active,
                                             in_item_reg.rail3_level, r3_high_reg, r3_hyst_reg);
        cond[dfm_pkg::CH_R3_LOW]  = low_cmp(deb_reg[dfm_pkg::CH_R3_LOW].active,
                                            in_item_reg.rail3_level, r3_low_reg, r3_hyst_reg);
        cond[dfm_pkg::CH_R5_HIGH] = high_cmp(deb_reg[dfm_pkg::CH_R5_HIGH].active,
                                             in_item_reg.rail5_level, r5_high_reg, r5_hyst_reg);
        cond[dfm_pkg::CH_R5_LOW]  = low_cmp(deb_reg[dfm_pkg::CH_R5_LOW].active,
                                            in_item_reg.rail5_level, r5_low_reg, r5_hyst_reg);
        cond[dfm_pkg::CH_DC_HIGH] = high_cmp(deb_reg[dfm_pkg::CH_DC_HIGH].active,
                                             in_item_reg.supply_level, dc_high_reg,
                                             r5_hyst_reg);
        cond[dfm_pkg::CH_AUDIO] = !fl[dfm_pkg::FL_AUD_PRESENT] || fl[dfm_pkg::FL_AUD_FAULT]
                                  || !fl[dfm_pkg::FL_AUD_RESP];
        // Unqualified track count is seen as clean
        cond[dfm_pkg::CH_TRACKS] = track_qual && (in_item_reg.track_count < dfm_pkg::MIN_TRACKS);
        cond[dfm_pkg::CH_WIFI] = !fl[dfm_pkg::FL_WIFI_PRESENT] || fl[dfm_pkg::FL_WIFI_ERROR];
        cond[dfm_pkg::CH_MEMORY] = !fl[dfm_pkg::FL_SUMMARY] || !fl[dfm_pkg::FL_FLASH_READY]
                                   || !fl[dfm_pkg::FL_MEM_READY];

        // Channels are independent: advance each debounce in parallel
        for (int i = 0; i < NCH; i++) begin
            deb_next[i] = deb_step(deb_reg[i], cond[i], dfm_pkg::SET_COUNT[i],
                                   dfm_pkg::CLEAR_COUNT[i]);
            sample_faults[i] = deb_next[i].active;
        end

        // Power absent: hold the rail channels and report them clean
        if (!fl[dfm_pkg::FL_POWER]) begin
            for (int i = 0; i < NCH; i++) begin
                if (dfm_pkg::POWER_CH_MASK[i]) begin
                    deb_next[i]      = deb_reg[i];
                    sample_faults[i] = 1'b0;
                end
            end
        end
        sample_faults[dfm_pkg::CH_TRACKS] = track_qual && deb_next[dfm_pkg::CH_TRACKS].active;
    end

    // Command handling
    logic [NCH-1:0] cur_faults, win_pre, win_out;

    always_comb begin
        auto_next = auto_reg;
        ext_next  = ext_reg;
        win_pre   = win_reg;
        case (in_cmd_reg)
            dfm_pkg::CMD_SAMPLE: begin
                auto_next = sample_faults;
                win_pre   = win_reg | sample_faults | ext_reg;
            end
            dfm_pkg::CMD_SET_EXT: begin
                ext_next = ext_reg | in_item_reg.fault_mask;
                win_pre  = win_reg | in_item_reg.fault_mask;
            end
            dfm_pkg::CMD_CLEAR_EXT: begin
                ext_next = ext_reg & ~in_item_reg.fault_mask;
            end
            dfm_pkg::CMD_RESET_WIN: begin
                win_pre = auto_reg | ext_reg;
            end
            default: begin
                // read, consume and unused codes change no fault bits here
            end
        endcase
        cur_faults = auto_next | ext_next;
        win_out    = win_pre | cur_faults;
        // Consume reports the window, then restarts it from the current faults
        win_next   = (in_cmd_reg == dfm_pkg::CMD_CONSUME) ? cur_faults : win_pre;

        out_next.current_faults    = cur_faults;
        out_next.window_faults     = win_out;
        out_next.current_module_ok = module_ok(cur_faults);
        out_next.window_module_ok  = module_ok(win_out);
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r3_high_reg <= dfm_pkg::RST_R3_HIGH;
            r3_low_reg  <= dfm_pkg::RST_R3_LOW;
            r3_hyst_reg <= dfm_pkg::RST_R3_HYST;
            r5_high_reg <= dfm_pkg::RST_R5_HIGH;
            r5_low_reg  <= dfm_pkg::RST_R5_LOW;
            dc_high_reg <= dfm_pkg::RST_DC_HIGH;
            r5_hyst_reg <= dfm_pkg::RST_R5_HYST;
            clk_min_reg <= dfm_pkg::RST_CLK_MIN;
        end else if (cfg_we) begin
            case (cfg_addr)
                dfm_pkg::REG_R3_HIGH: r3_high_reg <= cfg_wdata[11:0];
                dfm_pkg::REG_R3_LOW:  r3_low_reg  <= cfg_wdata[11:0];
                dfm_pkg::REG_R3_HYST: r3_hyst_reg <= cfg_wdata[7:0];
                dfm_pkg::REG_R5_HIGH: r5_high_reg <= cfg_wdata[11:0];
                dfm_pkg::REG_R5_LOW:  r5_low_reg  <= cfg_wdata[11:0];
                dfm_pkg::REG_DC_HIGH: dc_high_reg <= cfg_wdata[11:0];
                dfm_pkg::REG_R5_HYST: r5_hyst_reg <= cfg_wdata[7:0];
                dfm_pkg::REG_CLK_MIN: clk_min_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Request register: load whenever the slot is free or draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_tdata;
            in_cmd_reg  <= s_tuser;
        end
    end

    // Monitor state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg      <= '0;
            auto_reg     <= '0;
            ext_reg      <= '0;
            win_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (proc) begin
                // Advance debounce state on samples only
                if (in_cmd_reg == dfm_pkg::CMD_SAMPLE) begin
                    deb_reg <= deb_next;
                end
                auto_reg <= auto_next;
                ext_reg  <= ext_next;
                win_reg  <= win_next;
            end
            if (proc) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_reg <= out_next;
        end
    end

    // The window always covers the current faults
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((out_reg.window_faults & out_reg.current_faults)
                          == out_reg.current_faults))
        else $error("window result misses a current fault");

    // A sample without power leaves the rail debounce state untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_cmd_reg == dfm_pkg::CMD_SAMPLE
         && !in_item_reg.status_flags[dfm_pkg::FL_POWER])
        |=> $stable(deb_reg[dfm_pkg::CH_DC_HIGH:dfm_pkg::CH_R3_HIGH]))
        else $error("rail channels changed while power absent");

    // Reset leaves no fault bits behind
    assert property (@(posedge aclk)
        $past(!aresetn) |-> (ext_reg == '0 && win_reg == '0 && auto_reg == '0 && !m_tvalid_reg))
        else $error("fault state not cleared by reset");

    // An empty result register never blocks requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("request stalled with empty result register");

endmodule

// ===== verif/dfm_fault_checker.sv =====
// Result checker for the debounced fault monitor: watches the request, result and
// register write ports, predicts each result and compares it field by field.
// Depends on dfm_pkg for the payload layouts, command codes and register indexes.
`timescale 1ns / 1ps

module dfm_fault_checker
    import dfm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    output int           mismatch_count,
    output int           results_outstanding
);

    logic [11:0] r3_hi, r3_lo, r5_hi, r5_lo, dc_hi;
    logic [7:0]  r3_hyst, r5_hyst;
    logic [31:0] clk_min;

    bit          ch_on  [NUM_CH];
    logic [2:0]  ch_set [NUM_CH];
    logic [2:0]  ch_clr [NUM_CH];
    logic [NUM_CH-1:0] auto_flt, ext_flt, win_latch;

    out_item_t fault_report_q[$];

    function automatic bit debounce(int ch, bit cond, int nset, int nclr);
        if (ch_on[ch]) begin
            if (cond) begin
                ch_clr[ch] = '0;
                ch_set[ch] = 3'(nset);
            end else begin
                ch_set[ch] = '0;
                if (ch_clr[ch] < nclr) ch_clr[ch] = ch_clr[ch] + 3'd1;
                if (ch_clr[ch] >= nclr) begin
                    ch_on[ch]  = 1'b0;
                    ch_clr[ch] = '0;
                end
            end
        end else begin
            if (cond) begin
                ch_clr[ch] = '0;
                if (ch_set[ch] < nset) ch_set[ch] = ch_set[ch] + 3'd1;
                if (ch_set[ch] >= nset) begin
                    ch_on[ch]  = 1'b1;
                    ch_set[ch] = 3'(nset);
                end
            end else begin
                ch_set[ch] = '0;
                ch_clr[ch] = 3'(nclr);
            end
        end
        return ch_on[ch];
    endfunction

    // Hysteresis compares at full precision; set minus hysteresis may go negative
    function automatic bit over_limit(int ch, logic [11:0] lvl, logic [11:0] set,
                                      logic [7:0] hyst);
        if (ch_on[ch]) return int'(lvl) >= int'(set) - int'(hyst);
        return lvl > set;
    endfunction

    function automatic bit under_limit(int ch, logic [11:0] lvl, logic [11:0] set,
                                       logic [7:0] hyst);
        if (ch_on[ch]) return int'(lvl) <= int'(set) + int'(hyst);
        return lvl < set;
    endfunction

    function automatic logic [NUM_MOD-1:0] module_ok(logic [NUM_CH-1:0] f);
        logic [NUM_MOD-1:0] ok;
        ok[0] = (f[CH_RTC:CH_ACC] == '0);
        ok[1] = (f[CH_DC_HIGH:CH_R3_HIGH] == '0);
        ok[2] = (f[CH_TRACKS:CH_AUDIO] == '0);
        ok[3] = !f[CH_WIFI];
        ok[4] = !f[CH_MEMORY];
        return ok;
    endfunction

    function automatic logic [NUM_CH-1:0] sample_channels(in_item_t req);
        logic [13:0]       fl;
        logic [NUM_CH-1:0] f;
        bit                qual;
        bit                trk_on;
        fl = req.status_flags;
        f  = '0;
        f[CH_ACC] = debounce(CH_ACC, !fl[FL_ACC_READY], 1, 3);
        f[CH_RTC] = debounce(CH_RTC,
                             !fl[FL_RTC_READABLE] || req.clock_seconds < clk_min, 1, 1);
        // Rails keep their debounce state and report clean while power is absent
        if (fl[FL_POWER]) begin
            f[CH_R3_HIGH] = debounce(CH_R3_HIGH,
                over_limit(CH_R3_HIGH, req.rail3_level, r3_hi, r3_hyst), 3, 5);
            f[CH_R3_LOW] = debounce(CH_R3_LOW,
                under_limit(CH_R3_LOW, req.rail3_level, r3_lo, r3_hyst), 3, 5);
            f[CH_R5_HIGH] = debounce(CH_R5_HIGH,
                over_limit(CH_R5_HIGH, req.rail5_level, r5_hi, r5_hyst), 3, 5);
            f[CH_R5_LOW] = debounce(CH_R5_LOW,
                under_limit(CH_R5_LOW, req.rail5_level, r5_lo, r5_hyst), 3, 5);
            f[CH_DC_HIGH] = debounce(CH_DC_HIGH,
                over_limit(CH_DC_HIGH, req.supply_level, dc_hi, r5_hyst), 3, 5);
        end
        f[CH_AUDIO] = debounce(CH_AUDIO,
            !fl[FL_AUD_PRESENT] || fl[FL_AUD_FAULT] || !fl[FL_AUD_RESP], 3, 5);
        qual = fl[FL_AUD_PRESENT] && fl[FL_AUD_READY] && !fl[FL_AUD_FAULT] &&
               fl[FL_AUD_MODULE] && fl[FL_COUNT_VALID];
        trk_on = debounce(CH_TRACKS, qual && req.track_count < 16'd1, 1, 3);
        f[CH_TRACKS] = qual && trk_on;
        f[CH_WIFI] = debounce(CH_WIFI, !fl[FL_WIFI_PRESENT] || fl[FL_WIFI_ERROR], 3, 5);
        f[CH_MEMORY] = debounce(CH_MEMORY,
            !fl[FL_SUMMARY] || !fl[FL_FLASH_READY] || !fl[FL_MEM_READY], 1, 3);
        return f;
    endfunction

    function automatic out_item_t predict_fault_report(logic [2:0] cmd, in_item_t req);
        out_item_t         rpt;
        logic [NUM_CH-1:0] cur;
        case (cmd)
            CMD_SAMPLE: begin
                auto_flt  = sample_channels(req);
                win_latch = win_latch | auto_flt | ext_flt;
            end
            CMD_SET_EXT: begin
                ext_flt   = ext_flt | req.fault_mask;
                win_latch = win_latch | req.fault_mask;
            end
            CMD_CLEAR_EXT: ext_flt = ext_flt & ~req.fault_mask;
            CMD_RESET_WIN: win_latch = auto_flt | ext_flt;
            default: ;
        endcase
        cur = auto_flt | ext_flt;
        rpt.current_faults    = cur;
        rpt.window_faults     = win_latch | cur;
        rpt.current_module_ok = module_ok(cur);
        rpt.window_module_ok  = module_ok(rpt.window_faults);
        // Consume reports the window as it was, then restarts it from the current faults
        if (cmd == CMD_CONSUME) win_latch = cur;
        return rpt;
    endfunction

    task automatic check_field(string name, logic [10:0] want, logic [10:0] seen);
        if (want !== seen) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want, seen;
        if (!aresetn) begin
            r3_hi   = RST_R3_HIGH;
            r3_lo   = RST_R3_LOW;
            r3_hyst = RST_R3_HYST;
            r5_hi   = RST_R5_HIGH;
            r5_lo   = RST_R5_LOW;
            dc_hi   = RST_DC_HIGH;
            r5_hyst = RST_R5_HYST;
            clk_min = RST_CLK_MIN;
            for (int i = 0; i < NUM_CH; i++) begin
                ch_on[i]  = 1'b0;
                ch_set[i] = '0;
                ch_clr[i] = '0;
            end
            auto_flt  = '0;
            ext_flt   = '0;
            win_latch = '0;
            fault_report_q.delete();
        end else begin
            // A result leaves only after its request has passed the request and result registers, so compare first
            if (m_tvalid && m_tready) begin
                seen = out_item_t'(m_tdata);
                if (fault_report_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unrequested result, expected none actual %h",
                             $time, m_tdata);
                end else begin
                    want = fault_report_q.pop_front();
                    check_field("current_faults", want.current_faults, seen.current_faults);
                    check_field("window_faults", want.window_faults, seen.window_faults);
                    check_field("current_module_ok", 11'(want.current_module_ok),
                                11'(seen.current_module_ok));
                    check_field("window_module_ok", 11'(want.window_module_ok),
                                11'(seen.window_module_ok));
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_R3_HIGH: r3_hi   = cfg_wdata[11:0];
                    REG_R3_LOW:  r3_lo   = cfg_wdata[11:0];
                    REG_R3_HYST: r3_hyst = cfg_wdata[7:0];
                    REG_R5_HIGH: r5_hi   = cfg_wdata[11:0];
                    REG_R5_LOW:  r5_lo   = cfg_wdata[11:0];
                    REG_DC_HIGH: dc_hi   = cfg_wdata[11:0];
                    REG_R5_HYST: r5_hyst = cfg_wdata[7:0];
                    REG_CLK_MIN: clk_min = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                fault_report_q.push_back(predict_fault_report(s_tuser, in_item_t'(s_tdata)));
        end
        results_outstanding <= fault_report_q.size();
    end

endmodule

// ===== verif/debounced_fault_monitor_test.sv =====
// Top of the debounced fault monitor testbench: clock, reset, register setup,
// directed and random requests, result back-pressure and the final verdict.
// Depends on dfm_pkg, debounced_fault_monitor and dfm_fault_checker.
`timescale 1ns / 1ps

module debounced_fault_monitor_test;
    import dfm_pkg::*;

    // Far above the slowest legal run: ~830 requests with random gaps and stalls
    localparam int CYCLE_LIMIT = 200000;
    // Command codes the block treats as a plain read
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    // Every module healthy: all ready/present bits set, audio fault and
    // wireless error clear
    localparam logic [13:0] FLAGS_HEALTHY = 14'h3BEF;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    int  mismatch_count;
    int  results_outstanding;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stall_results;

    // Mirror of the register settings, used to aim levels at the thresholds
    logic [31:0] reg_shadow [8];
    // Slowly drifting status and rail levels so debounce runs can complete
    logic [13:0] flag_state;
    int          rail_lvl [3];

    debounced_fault_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    dfm_fault_checker fault_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random back-pressure, or a long hold-off when asked for,
    // counted here so the request side keeps offering meanwhile
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_results) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                stall_results = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[debounced_fault_monitor] ERROR");
        $finish;
    end

    function automatic in_item_t make_item(logic [13:0] flags, logic [11:0] r3,
                                           logic [11:0] r5, logic [11:0] dc,
                                           logic [15:0] tracks, logic [31:0] secs,
                                           logic [10:0] mask);
        in_item_t req;
        req               = '0;
        req.status_flags  = flags;
        req.rail3_level   = r3;
        req.rail5_level   = r5;
        req.supply_level  = dc;
        req.track_count   = tracks;
        req.clock_seconds = secs;
        req.fault_mask    = mask;
        return req;
    endfunction

    // Hold the request until it is taken; return at the accepting edge
    task automatic send_request(logic [2:0] cmd, in_item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every requested result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_outstanding != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all eight registers back to back; call only while drained
    task automatic program_regs(logic [31:0] r3hi, logic [31:0] r3lo, logic [31:0] r3hy,
                                logic [31:0] r5hi, logic [31:0] r5lo, logic [31:0] dchi,
                                logic [31:0] r5hy, logic [31:0] clkmin);
        reg_shadow[REG_R3_HIGH] = r3hi & 32'hFFF;
        reg_shadow[REG_R3_LOW]  = r3lo & 32'hFFF;
        reg_shadow[REG_R3_HYST] = r3hy & 32'hFF;
        reg_shadow[REG_R5_HIGH] = r5hi & 32'hFFF;
        reg_shadow[REG_R5_LOW]  = r5lo & 32'hFFF;
        reg_shadow[REG_DC_HIGH] = dchi & 32'hFFF;
        reg_shadow[REG_R5_HYST] = r5hy & 32'hFF;
        reg_shadow[REG_CLK_MIN] = clkmin;
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= reg_shadow[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Pick a level within the hysteresis plus two of one of the rail's thresholds
    function automatic int near_threshold(int rail);
        int set, hyst;
        case (rail)
            0: begin
                set  = $urandom_range(1) ? reg_shadow[REG_R3_HIGH] : reg_shadow[REG_R3_LOW];
                hyst = reg_shadow[REG_R3_HYST];
            end
            1: begin
                set  = $urandom_range(1) ? reg_shadow[REG_R5_HIGH] : reg_shadow[REG_R5_LOW];
                hyst = reg_shadow[REG_R5_HYST];
            end
            default: begin
                set  = reg_shadow[REG_DC_HIGH];
                hyst = reg_shadow[REG_R5_HYST];
            end
        endcase
        return set + int'($urandom_range(2 * hyst + 4)) - hyst - 2;
    endfunction

    task automatic send_random(int count);
        logic [2:0]  cmd;
        logic [31:0] secs;
        in_item_t    req;
        repeat (count) begin
            // Mostly samples, so debounce sequences run to completion
            cmd = ($urandom_range(99) < 65) ? CMD_SAMPLE : 3'($urandom_range(7));
            if ($urandom_range(7) == 0) flag_state[$urandom_range(13)] ^= 1'b1;
            if ($urandom_range(39) == 0) flag_state = 14'($urandom);
            if ($urandom_range(29) == 0) flag_state = FLAGS_HEALTHY;
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(19))
                    0:       rail_lvl[k] = $urandom_range(4095);
                    1, 2:    rail_lvl[k] = near_threshold(k);
                    default: rail_lvl[k] = rail_lvl[k] + int'($urandom_range(8)) - 4;
                endcase
                if (rail_lvl[k] < 0) rail_lvl[k] = 0;
                else if (rail_lvl[k] > 4095) rail_lvl[k] = 4095;
            end
            case ($urandom_range(3))
                0:       secs = $urandom;
                1:       secs = reg_shadow[REG_CLK_MIN] + 32'($urandom_range(4)) - 32'd2;
                default: secs = 32'hFFFF_FFFF - 32'($urandom_range(1000));
            endcase
            req = make_item(flag_state, 12'(rail_lvl[0]), 12'(rail_lvl[1]),
                            12'(rail_lvl[2]),
                            ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                            secs, 11'($urandom));
            send_request(cmd, req);
        end
    endtask

    // Directed requests against the reset thresholds
    task automatic run_directed();
        logic [13:0] no_power;
        no_power = FLAGS_HEALTHY & ~(14'd1 << FL_POWER);
        // All healthy, levels mid-band
        send_request(CMD_SAMPLE, make_item(FLAGS_HEALTHY, 330, 500, 700, 5, 50000000, 0));
        // Everything missing; power absent so rails hold
        send_request(CMD_SAMPLE, make_item(14'h0000, 0, 0, 0, 0, 0, 0));
        // All flags set: audio fault and ready together, wireless error; rails at top
        repeat (3)
            send_request(CMD_SAMPLE, make_item(14'h3FFF, 4095, 4095, 4095, 16'hFFFF,
                                               32'hFFFF_FFFF, 11'h7FF));
        // Power drops: rail bits read clean while their state holds
        send_request(CMD_SAMPLE, make_item(no_power, 4095, 4095, 4095, 5, 50000000, 0));
        // Exactly at set minus hysteresis: still active
        send_request(CMD_SAMPLE, make_item(FLAGS_HEALTHY, 355, 540, 790, 5, 50000000, 0));
        // One below the clear point long enough to release
        repeat (5)
            send_request(CMD_SAMPLE, make_item(FLAGS_HEALTHY, 354, 539, 789, 5,
                                               50000000, 0));
        // Undervoltage on both low rails
        repeat (3)
            send_request(CMD_SAMPLE, make_item(FLAGS_HEALTHY, 299, 449, 700, 5,
                                               50000000, 0));
        // No tracks while qualified; clock one below the valid minimum
        send_request(CMD_SAMPLE, make_item(FLAGS_HEALTHY, 305, 460, 700, 0, 41903999, 0));
        send_request(CMD_SAMPLE, make_item(FLAGS_HEALTHY, 330, 500, 700, 0, 41904000, 0));
        // External faults and the window commands, spare codes included
        send_request(CMD_SET_EXT, make_item(0, 0, 0, 0, 0, 0, 11'h7FF));
        send_request(CMD_CLEAR_EXT, make_item(0, 0, 0, 0, 0, 0, 11'h555));
        send_request(CMD_READ, make_item(0, 0, 0, 0, 0, 0, 11'h2AA));
        send_request(CMD_CONSUME, make_item(0, 0, 0, 0, 0, 0, 0));
        send_request(CMD_CLEAR_EXT, make_item(0, 0, 0, 0, 0, 0, 11'h7FF));
        send_request(CMD_CONSUME, make_item(0, 0, 0, 0, 0, 0, 0));
        send_request(CMD_RESET_WIN, make_item(0, 0, 0, 0, 0, 0, 0));
        send_request(CMD_SPARE_A, make_item(14'h3FFF, 0, 0, 0, 0, 0, 11'h7FF));
        send_request(CMD_SPARE_B, make_item(14'h3FFF, 0, 0, 0, 0, 0, 11'h7FF));
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_R3_HIGH;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_READ;
        send_idle_pct = 25;
        recv_idle_pct = 48;
        stall_results = 1'b0;
        reg_shadow[REG_R3_HIGH] = RST_R3_HIGH;
        reg_shadow[REG_R3_LOW]  = RST_R3_LOW;
        reg_shadow[REG_R3_HYST] = RST_R3_HYST;
        reg_shadow[REG_R5_HIGH] = RST_R5_HIGH;
        reg_shadow[REG_R5_LOW]  = RST_R5_LOW;
        reg_shadow[REG_DC_HIGH] = RST_DC_HIGH;
        reg_shadow[REG_R5_HYST] = RST_R5_HYST;
        reg_shadow[REG_CLK_MIN] = RST_CLK_MIN;
        flag_state = FLAGS_HEALTHY;
        rail_lvl[0] = 330;
        rail_lvl[1] = 500;
        rail_lvl[2] = 700;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset thresholds; sender idles lightly, receiver heavily
        run_directed();
        send_random(230);
        wait_drained();

        // Extremes: thresholds at the rails, widest and zero hysteresis, latest clock
        program_regs(0, 4095, 255, 4095, 0, 0, 0, 32'hFFFF_FFFF);
        send_idle_pct = 48;
        recv_idle_pct = 25;
        send_random(170);
        wait_drained();

        // Random settings at full rate, with a long result hold-off to fill the block
        program_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                     $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(255), $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_results = 1'b1;
        send_random(200);
        wait_drained();

        // Opposite extremes: zero rail-3 hysteresis, wide rail-5 and supply hysteresis, clock always valid
        program_regs(4095, 0, 0, 0, 4095, 4095, 255, 0);
        send_random(200);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[debounced_fault_monitor] OK");
        else
            $display("[debounced_fault_monitor] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/dfm_pkg.sv
design/debounced_fault_monitor.sv
verif/dfm_fault_checker.sv
verif/debounced_fault_monitor_test.sv
